[rtl/ip_protocol_and_port_histogram_unit_defines.svh]
// Assertion macros shared by the histogram checker
`ifndef IP_PROTOCOL_AND_PORT_HISTOGRAM_UNIT_DEFINES_SVH
`define IP_PROTOCOL_AND_PORT_HISTOGRAM_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IPH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("histogram check failed");

// next-cycle implication, disabled during reset
`define IPH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("histogram check failed");

`endif

[rtl/iph_pkg.sv]
// Types and constants of the protocol and port histogram unit
package iph_pkg;

  localparam int COUNT_W      = 32;
  localparam int OUT_W        = 32;
  localparam int PORT_BUCKETS = 1024;
  localparam int PORT_IDX_W   = $clog2(PORT_BUCKETS);
  localparam int PROTO_ENTRIES = 256;
  localparam int PROTO_IDX_W  = 8;
  localparam int IDX_W        = 10;
  localparam int POS_W        = 7;

  localparam logic [POS_W-1:0] ETH_TYPE_POS = 7'd12;
  localparam logic [POS_W-1:0] IP_START     = 7'd14;
  localparam logic [POS_W-1:0] PROTO_POS    = 7'd23;
  localparam logic [POS_W-1:0] POS_MAX      = 7'd127;
  localparam logic [7:0]       ETH_TYPE_HI  = 8'h08;
  localparam logic [7:0]       ETH_TYPE_LO  = 8'h00;
  localparam logic [7:0]       PROTO_TCP    = 8'd6;
  localparam logic [7:0]       PROTO_UDP    = 8'd17;

  typedef enum logic [1:0] {
    FN_BYTE     = 2'd0,
    FN_RD_PROTO = 2'd1,
    FN_RD_PORT  = 2'd2,
    FN_CLEAR    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_INIT_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_REPLY,
    ST_CMT_READ,
    ST_CMT_WRITE,
    ST_CLEAR,
    ST_CLR_REPLY
  } state_t;

  typedef struct packed {
    logic parse_byte;
    logic latch_cmd;
    logic rd_commit;
    logic commit_wr;
    logic clr_step;
    logic frame_clear;
    logic reply_clear;
  } iph_cmd_t;

  typedef struct packed {
    logic clr_last;
  } iph_stat_t;

endpackage

[rtl/iph_ctrl.sv]
// Controller state machine of the histogram unit
module iph_ctrl import iph_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [1:0] func,
  input  logic      last_byte,
  input  iph_stat_t stat,
  output iph_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  state_t state, state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT_CLEAR: if (stat.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (func)
            FN_BYTE:     if (last_byte) state_next = ST_CMT_READ;
            FN_RD_PROTO: state_next = ST_READ;
            FN_RD_PORT:  state_next = ST_READ;
            FN_CLEAR:    state_next = ST_CLEAR;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ:      state_next = ST_REPLY;
      ST_REPLY:     state_next = ST_IDLE;
      ST_CMT_READ:  state_next = ST_CMT_WRITE;
      ST_CMT_WRITE: state_next = ST_IDLE;
      ST_CLEAR:     if (stat.clr_last) state_next = ST_CLR_REPLY;
      ST_CLR_REPLY: state_next = ST_IDLE;
      default:      state_next = ST_INIT_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      ST_INIT_CLEAR: begin
        cmd.clr_step    = 1'b1;
        cmd.frame_clear = 1'b1;
      end
      ST_IDLE: begin
        busy = 1'b0;
        cmd.parse_byte = accept && (func == FN_BYTE);
        cmd.latch_cmd  = accept;
      end
      ST_READ: ;
      ST_REPLY: done = 1'b1;
      ST_CMT_READ: cmd.rd_commit = 1'b1;
      ST_CMT_WRITE: begin
        cmd.commit_wr   = 1'b1;
        cmd.frame_clear = 1'b1;
      end
      ST_CLEAR: begin
        cmd.clr_step    = 1'b1;
        cmd.frame_clear = 1'b1;
      end
      ST_CLR_REPLY: begin
        done            = 1'b1;
        cmd.reply_clear = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[rtl/iph_datapath.sv]
// Header parser, count memories and reply path of the histogram unit
module iph_datapath import iph_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  iph_cmd_t         cmd,
  output iph_stat_t        stat,
  input  logic [1:0]       func,
  input  logic [7:0]       data_byte,
  input  logic [IDX_W-1:0] table_index,
  input  logic             port_table,
  output logic [OUT_W-1:0] count_value,
  output logic             reply_kind
);

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + COUNT_W'(1);
  endfunction

  // per-frame parse state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             is_ipv4, is_ipv4_next;
  logic [7:0]       proto_number, proto_number_next;
  logic [3:0]       header_words, header_words_next;
  logic [15:0]      source_port, source_port_next;
  logic [1:0]       have_fields, have_fields_next;

  logic [3:0]       hw_eff;
  logic [POS_W-1:0] port_off;

  // latched read command
  logic [IDX_W-1:0] cmd_idx;
  logic             cmd_port;
  logic             cmd_table;

  logic [PORT_IDX_W-1:0] clr_addr;

  logic [COUNT_W-1:0] proto_mem [PROTO_ENTRIES];
  logic [COUNT_W-1:0] tcp_mem   [PORT_BUCKETS];
  logic [COUNT_W-1:0] udp_mem   [PORT_BUCKETS];
  logic [COUNT_W-1:0] proto_rd, tcp_rd, udp_rd;

  logic [PROTO_IDX_W-1:0] proto_raddr;
  logic [PORT_IDX_W-1:0]  port_raddr, bucket;
  logic do_proto, do_tcp, do_udp;
  logic in_proto, in_port;
  logic [COUNT_W-1:0] rd_val;

  // IHL byte takes effect for the port offset in its own cycle
  assign hw_eff   = (byte_position == IP_START) ? data_byte[3:0] : header_words;
  assign port_off = IP_START + {1'b0, hw_eff, 2'b00};

  always_comb begin
    byte_position_next = byte_position;
    is_ipv4_next       = is_ipv4;
    proto_number_next  = proto_number;
    header_words_next  = header_words;
    source_port_next   = source_port;
    have_fields_next   = have_fields;
    if (byte_position == ETH_TYPE_POS) is_ipv4_next = (data_byte == ETH_TYPE_HI);
    if (byte_position == ETH_TYPE_POS + POS_W'(1)) begin
      is_ipv4_next = is_ipv4 && (data_byte == ETH_TYPE_LO);
    end
    if (byte_position == IP_START) header_words_next = data_byte[3:0];
    if (byte_position == PROTO_POS) begin
      proto_number_next   = data_byte;
      have_fields_next[0] = 1'b1;
    end
    if (byte_position >= IP_START && byte_position < POS_MAX) begin
      if (byte_position == port_off) source_port_next[15:8] = data_byte;
      if (byte_position == port_off + POS_W'(1)) begin
        source_port_next[7:0] = data_byte;
        have_fields_next[1]   = 1'b1;
      end
    end
    if (byte_position < POS_MAX) byte_position_next = byte_position + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clear) begin
      byte_position <= '0;
      is_ipv4       <= 1'b0;
      proto_number  <= '0;
      header_words  <= '0;
      source_port   <= '0;
      have_fields   <= '0;
    end else if (cmd.parse_byte) begin
      byte_position <= byte_position_next;
      is_ipv4       <= is_ipv4_next;
      proto_number  <= proto_number_next;
      header_words  <= header_words_next;
      source_port   <= source_port_next;
      have_fields   <= have_fields_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_cmd) begin
      cmd_idx   <= table_index;
      cmd_port  <= (func == FN_RD_PORT);
      cmd_table <= port_table;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= stat.clr_last ? '0 : clr_addr + PORT_IDX_W'(1);
    end
  end

  assign stat.clr_last = (clr_addr == PORT_IDX_W'(PORT_BUCKETS - 1));

  // ports 1..PORT_BUCKETS-1 own a bucket, the rest share bucket 0
  assign bucket = (source_port != '0 && source_port < 16'(PORT_BUCKETS))
                  ? source_port[PORT_IDX_W-1:0] : '0;

  assign do_proto = is_ipv4 && have_fields[0];
  assign do_tcp   = do_proto && have_fields[1] && (proto_number == PROTO_TCP);
  assign do_udp   = do_proto && have_fields[1] && (proto_number == PROTO_UDP);

  assign proto_raddr = cmd.rd_commit ? proto_number : cmd_idx[PROTO_IDX_W-1:0];
  assign port_raddr  = cmd.rd_commit ? bucket : cmd_idx[PORT_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      proto_mem[clr_addr[PROTO_IDX_W-1:0]] <= '0;
    end else if (cmd.commit_wr && do_proto) begin
      proto_mem[proto_number] <= sat_inc(proto_rd);
    end
    proto_rd <= proto_mem[proto_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      tcp_mem[clr_addr] <= '0;
    end else if (cmd.commit_wr && do_tcp) begin
      tcp_mem[bucket] <= sat_inc(tcp_rd);
    end
    tcp_rd <= tcp_mem[port_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      udp_mem[clr_addr] <= '0;
    end else if (cmd.commit_wr && do_udp) begin
      udp_mem[bucket] <= sat_inc(udp_rd);
    end
    udp_rd <= udp_mem[port_raddr];
  end

  assign in_proto = (cmd_idx < IDX_W'(PROTO_ENTRIES));
  assign in_port  = ({1'b0, cmd_idx} < (IDX_W + 1)'(PORT_BUCKETS));

  always_comb begin
    if (cmd_port) begin
      rd_val = in_port ? (cmd_table ? udp_rd : tcp_rd) : '0;
    end else begin
      rd_val = in_proto ? proto_rd : '0;
    end
  end

  assign count_value = cmd.reply_clear ? '0 : OUT_W'(rd_val);
  assign reply_kind  = cmd.reply_clear;

endmodule

[rtl/ip_protocol_and_port_histogram_unit.sv]
// Top level of the IPv4 protocol and source-port histogram unit
//
// Commands enter on start/func while busy is low. func FN_BYTE feeds one
// Ethernet frame byte (last_byte marks the end of the frame); FN_RD_PROTO
// and FN_RD_PORT read one count (table_index, port_table); FN_CLEAR zeroes
// all counts. Each transaction is taken at a clock edge with start high and
// busy low.
// A frame byte that is not the last is taken without leaving idle, so
// bytes stream at one per cycle. The last byte then passes through a
// read state and a write state on the count memories to bump the protocol
// and port counters (saturating). A read passes through a read state and
// a reply state; done is high for one cycle in the reply state, with the
// count on count_value and reply_kind 0. A clear runs the clearing pass,
// which writes one address of all three memories per cycle, then done
// pulses with reply_kind 1 and count_value 0. After reset the same
// clearing pass runs with busy high and no reply. Results are shown for
// exactly one cycle and cannot be held off by the receiver.
module ip_protocol_and_port_histogram_unit import iph_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       func,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [IDX_W-1:0] table_index,
  input  logic             port_table,
  output logic             done,
  output logic [OUT_W-1:0] count_value,
  output logic             reply_kind
);

  iph_cmd_t  cmd;
  iph_stat_t stat;

  iph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .last_byte (last_byte),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  iph_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .data_byte   (data_byte),
    .table_index (table_index),
    .port_table  (port_table),
    .count_value (count_value),
    .reply_kind  (reply_kind)
  );

endmodule

[rtl/iph_checker.sv]
// Port-level checker for the histogram unit, bound to the top level
`include "ip_protocol_and_port_histogram_unit_defines.svh"

module iph_checker import iph_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic [1:0]       func,
  input logic             last_byte,
  input logic             done,
  input logic [OUT_W-1:0] count_value,
  input logic             reply_kind
);

  // a reply is never shown while a new transaction could be taken
  `IPH_ASSERT_NOW(a_done_busy, done, busy)
  `IPH_ASSERT_NEXT(a_done_single, done, !done)
  // mid-frame bytes stream without back-pressure
  `IPH_ASSERT_NEXT(a_byte_stream,
                   start && !busy && func == FN_BYTE && !last_byte, !busy && !done)
  `IPH_ASSERT_NEXT(a_clear_busy, start && !busy && func == FN_CLEAR, busy)
  `IPH_ASSERT_NOW(a_clear_zero, done && reply_kind, count_value == '0)

endmodule

bind ip_protocol_and_port_histogram_unit iph_checker u_iph_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .func        (func),
  .last_byte   (last_byte),
  .done        (done),
  .count_value (count_value),
  .reply_kind  (reply_kind)
);

[test/histogram_checker.sv]
// Reply predictor and scoreboard for the protocol and port histogram unit
module histogram_checker import iph_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       func,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [IDX_W-1:0] table_index,
  input  logic             port_table,
  input  logic             done,
  input  logic [OUT_W-1:0] count_value,
  input  logic             reply_kind,
  output int               errors,
  output int               pending
);

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct {
    logic [OUT_W-1:0] count;
    logic             kind;
  } reply_t;

  count_t proto_hist [PROTO_ENTRIES];
  count_t tcp_hist   [PORT_BUCKETS];
  count_t udp_hist   [PORT_BUCKETS];

  // per-frame parse state
  logic [POS_W-1:0] frame_pos;
  logic             ipv4_frame;
  logic [7:0]       ip_proto;
  logic [3:0]       ihl;
  logic [15:0]      port_word;
  logic             proto_seen;
  logic             port_seen;

  reply_t expected_replies[$];
  int     error_count = 0;

  function automatic count_t bumped(count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic void reset_frame();
    frame_pos  = '0;
    ipv4_frame = 1'b0;
    ip_proto   = '0;
    ihl        = '0;
    port_word  = '0;
    proto_seen = 1'b0;
    port_seen  = 1'b0;
  endfunction

  function automatic void clear_counts();
    reset_frame();
    foreach (proto_hist[i]) proto_hist[i] = '0;
    foreach (tcp_hist[i]) tcp_hist[i] = '0;
    foreach (udp_hist[i]) udp_hist[i] = '0;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    int port_at;
    if (frame_pos == ETH_TYPE_POS) ipv4_frame = (b == ETH_TYPE_HI);
    if (frame_pos == ETH_TYPE_POS + 1) ipv4_frame = ipv4_frame && (b == ETH_TYPE_LO);
    if (frame_pos == IP_START) ihl = b[3:0];
    if (frame_pos == PROTO_POS) begin
      ip_proto   = b;
      proto_seen = 1'b1;
    end
    if (frame_pos >= IP_START && frame_pos < POS_MAX) begin
      // with IHL 0 the IHL byte doubles as the port high byte
      port_at = IP_START + 4 * ihl;
      if (frame_pos == port_at) port_word[15:8] = b;
      if (frame_pos == port_at + 1) begin
        port_word[7:0] = b;
        port_seen      = 1'b1;
      end
    end
    if (frame_pos < POS_MAX) frame_pos++;
  endfunction

  function automatic void commit_frame();
    logic [PORT_IDX_W-1:0] bucket;
    if (!ipv4_frame || !proto_seen) return;
    proto_hist[ip_proto] = bumped(proto_hist[ip_proto]);
    if (!port_seen) return;
    bucket = (port_word >= 1 && port_word < PORT_BUCKETS) ? port_word[PORT_IDX_W-1:0] : '0;
    if (ip_proto == PROTO_TCP) tcp_hist[bucket] = bumped(tcp_hist[bucket]);
    else if (ip_proto == PROTO_UDP) udp_hist[bucket] = bumped(udp_hist[bucket]);
  endfunction

  function automatic reply_t read_count(func_t op, logic [IDX_W-1:0] idx, logic udp_sel);
    reply_t r;
    count_t v;
    v = '0;
    if (op == FN_RD_PROTO) begin
      if (idx < PROTO_ENTRIES) v = proto_hist[idx[PROTO_IDX_W-1:0]];
    end else if (idx < PORT_BUCKETS) begin
      v = udp_sel ? udp_hist[idx[PORT_IDX_W-1:0]] : tcp_hist[idx[PORT_IDX_W-1:0]];
    end
    r.count = v[OUT_W-1:0];
    r.kind  = KIND_READ;
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      clear_counts();
      expected_replies.delete();
    end else begin
      if (done) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with none expected: count_value %0h reply_kind %0b",
                   $time, count_value, reply_kind);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          if (count_value !== want.count) begin
            $display("%0t: count_value expected %0h, got %0h", $time, want.count, count_value);
            error_count++;
          end
          if (reply_kind !== want.kind) begin
            $display("%0t: reply_kind expected %0b, got %0b", $time, want.kind, reply_kind);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        case (func_t'(func))
          FN_BYTE: begin
            take_byte(data_byte);
            if (last_byte) begin
              commit_frame();
              reset_frame();
            end
          end
          FN_CLEAR: begin
            clear_counts();
            want = '{count: '0, kind: KIND_CLEAR};
            expected_replies = {expected_replies, want};
          end
          default: begin
            want = read_count(func_t'(func), table_index, port_table);
            expected_replies = {expected_replies, want};
          end
        endcase
      end
    end
    errors  <= error_count;
    pending <= expected_replies.size();
  end

endmodule

[test/testbench.sv]
// Stimulus and verdict for the protocol and port histogram unit
module testbench;
  import iph_pkg::*;

  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NOISE_CLEARS = 3;  // each clear costs a full pass over the memories
  localparam int FRAME_MAX    = 150;

  typedef enum int { FR_GOOD, FR_SHORT, FR_LONG, FR_NOT_IP, FR_JUNK } frame_kind_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       func;
  logic [7:0]       data_byte;
  logic             last_byte;
  logic [IDX_W-1:0] table_index;
  logic             port_table;
  logic             done;
  logic [OUT_W-1:0] count_value;
  logic             reply_kind;
  int               errors;
  int               pending;

  int cycles      = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int clears_left = NOISE_CLEARS;

  // recently counted protocols and port buckets, so reads hit nonzero counts
  logic [7:0]            recent_proto  [8];
  logic [PORT_IDX_W-1:0] recent_bucket [8];
  logic                  recent_udp    [8];
  int                    recent_fill = 0;

  ip_protocol_and_port_histogram_unit u_dut (.*);

  histogram_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic issue(func_t op, logic [7:0] b, logic last, logic [IDX_W-1:0] idx, logic tbl);
    start       <= 1'b1;
    func        <= op;
    data_byte   <= b;
    last_byte   <= last;
    table_index <= idx;
    port_table  <= tbl;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
  endtask

  // sender bursts: a gap opens only when the current burst runs out
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    gap         = $urandom_range(1, 8);
    start       <= 1'b0;
    func        <= 2'($urandom);
    data_byte   <= 8'($urandom);
    last_byte   <= 1'($urandom);
    table_index <= IDX_W'($urandom);
    port_table  <= 1'($urandom);
    repeat (gap) @(posedge clk);
  endtask

  task automatic clear_all();
    pace();
    issue(FN_CLEAR, 8'($urandom), 1'($urandom), IDX_W'($urandom), 1'($urandom));
  endtask

  task automatic read_back();
    logic [IDX_W-1:0] idx;
    logic             tbl;
    int               slot;
    slot = (recent_fill > 0) ? $urandom_range(0, (recent_fill > 8) ? 7 : recent_fill - 1) : 0;
    tbl  = 1'($urandom);
    pace();
    if ($urandom_range(0, 2) == 0) begin
      if (recent_fill > 0 && $urandom_range(0, 1) == 1) idx = IDX_W'(recent_proto[slot]);
      else if ($urandom_range(0, 1) == 1) idx = IDX_W'($urandom_range(0, PROTO_ENTRIES - 1));
      else idx = IDX_W'($urandom);
      issue(FN_RD_PROTO, 8'($urandom), 1'($urandom), idx, tbl);
    end else begin
      if (recent_fill > 0 && $urandom_range(0, 2) != 0) begin
        idx = IDX_W'(recent_bucket[slot]);
        tbl = recent_udp[slot];
      end else begin
        idx = IDX_W'($urandom);
      end
      issue(FN_RD_PORT, 8'($urandom), 1'($urandom), idx, tbl);
    end
  endtask

  task automatic send_frame(frame_kind_t kind, logic [3:0] ihl, logic [7:0] proto,
                            logic [15:0] port);
    logic [7:0]  frame_bytes [FRAME_MAX];
    logic [15:0] sent_port;
    int          port_at;
    int          full;
    int          len;
    int          slot;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom);
    port_at = IP_START + 4 * ihl;
    full    = (port_at + 2 > PROTO_POS + 1) ? port_at + 2 : PROTO_POS + 1;
    if (kind != FR_JUNK) begin
      frame_bytes[ETH_TYPE_POS]     = ETH_TYPE_HI;
      frame_bytes[ETH_TYPE_POS + 1] = ETH_TYPE_LO;
      if (kind == FR_NOT_IP) begin
        case ($urandom_range(0, 2))
          0: frame_bytes[ETH_TYPE_POS] ^= 8'(1 << $urandom_range(0, 7));
          1: frame_bytes[ETH_TYPE_POS + 1] ^= 8'(1 << $urandom_range(0, 7));
          default: frame_bytes[ETH_TYPE_POS + 1] = 8'($urandom_range(1, 255));
        endcase
      end
      frame_bytes[IP_START]  = (ihl == 0) ? {port[15:12], 4'h0} : {4'h4, ihl};
      frame_bytes[PROTO_POS] = proto;
      if (port_at != IP_START) frame_bytes[port_at] = port[15:8];
      frame_bytes[port_at + 1] = port[7:0];
    end
    case (kind)
      FR_SHORT: len = $urandom_range(1, full - 1);
      FR_LONG:  len = $urandom_range(POS_MAX + 1, FRAME_MAX);
      FR_JUNK:  len = $urandom_range(1, 40);
      default:  len = full + $urandom_range(0, 6);
    endcase
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        read_back();
      end else if (clears_left > 0 && $urandom_range(0, 999) == 0) begin
        clears_left--;
        clear_all();
      end
      pace();
      issue(FN_BYTE, frame_bytes[i], i == len - 1, IDX_W'($urandom), 1'($urandom));
    end
    if (kind == FR_GOOD || kind == FR_LONG) begin
      slot      = recent_fill % 8;
      sent_port = {frame_bytes[port_at], frame_bytes[port_at + 1]};
      recent_proto[slot]  = frame_bytes[PROTO_POS];
      recent_bucket[slot] = (sent_port >= 1 && sent_port < PORT_BUCKETS) ?
                            sent_port[PORT_IDX_W-1:0] : '0;
      recent_udp[slot]    = (frame_bytes[PROTO_POS] == PROTO_UDP);
      recent_fill++;
    end
  endtask

  task automatic random_frame(int n);
    frame_kind_t kind;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] port;
    int          pick;
    // first frames walk through every frame shape, then the port extremes
    if (n < 5) begin
      kind = frame_kind_t'(n);
    end else if (n < 10) begin
      kind = FR_GOOD;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 65) kind = FR_GOOD;
      else if (pick < 77) kind = FR_SHORT;
      else if (pick < 80) kind = FR_LONG;
      else if (pick < 90) kind = FR_NOT_IP;
      else kind = FR_JUNK;
    end
    ihl  = ($urandom_range(0, 1) == 1) ? 4'd5 : 4'($urandom);
    pick = $urandom_range(0, 9);
    if (n >= 5 && n < 10) proto = n[0] ? PROTO_UDP : PROTO_TCP;
    else if (pick < 4) proto = PROTO_TCP;
    else if (pick < 8) proto = PROTO_UDP;
    else proto = 8'($urandom);
    pick = (n >= 5 && n < 10) ? n - 5 : $urandom_range(0, 9);
    case (pick)
      0: port = 16'd0;
      1: port = 16'(PORT_BUCKETS - 1);
      2: port = 16'(PORT_BUCKETS);
      3: port = 16'd1;
      4: port = 16'hFFFF;
      5, 6, 7: port = 16'($urandom_range(1, PORT_BUCKETS - 1));
      default: port = 16'($urandom);
    endcase
    send_frame(kind, ihl, proto, port);
  endtask

  initial begin
    int frame_count;
    int random_base;
    bit paused;
    frame_count = 0;
    paused      = 1'b0;
    rst         <= 1'b1;
    start       <= 1'b0;
    func        <= FN_BYTE;
    data_byte   <= '0;
    last_byte   <= 1'b0;
    table_index <= '0;
    port_table  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty tables, in and out of range
    issue(FN_RD_PROTO, 8'h00, 1'b0, IDX_W'(0), 1'b0);
    issue(FN_RD_PROTO, 8'hFF, 1'b1, IDX_W'(PROTO_ENTRIES - 1), 1'b1);
    issue(FN_RD_PROTO, 8'h00, 1'b0, IDX_W'(PROTO_ENTRIES), 1'b0);
    issue(FN_RD_PORT, 8'hFF, 1'b1, IDX_W'(0), 1'b0);
    issue(FN_RD_PORT, 8'h00, 1'b0, IDX_W'(PORT_BUCKETS - 1), 1'b1);
    // IHL 0: the IHL byte is also the port high byte
    send_frame(FR_GOOD, 4'd0, PROTO_TCP, 16'h00FF);
    issue(FN_RD_PROTO, 8'h00, 1'b0, IDX_W'(PROTO_TCP), 1'b0);
    issue(FN_RD_PORT, 8'h00, 1'b0, IDX_W'(255), 1'b0);
    clear_all();
    issue(FN_RD_PORT, 8'h00, 1'b0, IDX_W'(255), 1'b0);

    random_base = items_sent;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      random_frame(frame_count);
      frame_count++;
      repeat ($urandom_range(0, 3)) read_back();
      if (!paused && items_sent - random_base > RANDOM_ITEMS / 2) begin
        // hold off until every reply is back, then clear mid-run
        paused = 1'b1;
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        burst_left = $urandom_range(1, 40);
        clear_all();
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
